// ----- src/agd_pkg.sv -----
// Package for the accelerometer gesture detector: beat structs, face codes,
// configuration register indexes and reset values.
// No dependencies.
package agd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // One g in units of 1/4096 g.
    localparam logic signed [16:0] ONE_G = 17'sd4096;

    typedef enum logic [2:0] {
        ORIENT_TOP    = 3'd0,
        ORIENT_BOTTOM = 3'd1,
        ORIENT_FRONT  = 3'd2,
        ORIENT_BACK   = 3'd3,
        ORIENT_RIGHT  = 3'd4,
        ORIENT_LEFT   = 3'd5,
        ORIENT_NONE   = 3'd6
    } t_face;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHAKE_THRESHOLD   = 3'd0,
        CFG_SHAKE_DURATION_MS = 3'd1,
        CFG_TAP_THRESHOLD     = 3'd2,
        CFG_TAP_COOLDOWN_MS   = 3'd3,
        CFG_FACE_THRESHOLD    = 3'd4,
        CFG_FACE_STABLE_MS    = 3'd5
    } t_cfg_idx;

    localparam logic [15:0] RST_SHAKE_THRESHOLD   = 16'd6144;
    localparam logic [15:0] RST_SHAKE_DURATION_MS = 16'd500;
    localparam logic [14:0] RST_TAP_THRESHOLD     = 15'd2048;
    localparam logic [15:0] RST_TAP_COOLDOWN_MS   = 16'd300;
    localparam logic [14:0] RST_FACE_THRESHOLD    = 15'd3277;
    localparam logic [15:0] RST_FACE_STABLE_MS    = 16'd1000;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic        [31:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic       shake_seen;
        logic       tap_seen;
        logic [2:0] new_face;
    } t_out_item;

endpackage

// ----- src/accel_gesture_detector.sv -----
// Top level of the accelerometer gesture detector: shake, tap and up-face
// detection on one sample per beat. Depends on agd_pkg.
//
// Usage:
//   Samples enter on the input channel (i_in_valid / o_in_ready, payload
//   i_in_item: x, y, z in 1/4096 g and a millisecond timestamp). Every
//   sample yields exactly one result beat on the output channel
//   (o_out_valid / i_out_ready, payload o_out_item: shake_seen, tap_seen,
//   new_face, where new_face is ORIENT_NONE when no face change is reported).
//   An accepted sample is registered with the squares of x and y; the
//   detectors are then evaluated against the state and load the result
//   register, which drives o_out_valid. Throughput is one sample per cycle
//   while the receiver does not stall; it is set by the single evaluation
//   stage, which reads and updates the detector state in the same cycle.
//   When the receiver stalls, the result register holds its beat, the
//   input register keeps one more sample, and o_in_ready then drops.
//   Configuration writes (i_cfg_valid / o_cfg_ready, index and data) are
//   always taken and must be made while the block is idle; unknown
//   indexes are ignored. Reset restores the default configuration, clears
//   the shake and tap state and sets the reported face to top.
module accel_gesture_detector (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  agd_pkg::t_in_item                  i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output agd_pkg::t_out_item                 o_out_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [agd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [agd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration registers. The shake threshold is only ever used squared,
    // so the square is stored when the threshold is written.
    logic [31:0] r_lim2;
    logic [15:0] r_shake_dur;
    logic [14:0] r_tap_thr;
    logic [15:0] r_tap_cool;
    logic [14:0] r_face_thr;
    logic [15:0] r_face_stable;

    // Input stage.
    logic              r_in_valid;
    agd_pkg::t_in_item r_in;
    logic [30:0]       r_sq_x;
    logic [30:0]       r_sq_y;

    // Detector state.
    logic          r_shake_active;
    logic [31:0]   r_shake_begin;
    logic [31:0]   r_last_tap;
    agd_pkg::t_face r_reported_face;
    agd_pkg::t_face r_pending_face;
    logic [31:0]   r_pending_since;

    // Output stage.
    logic               r_out_valid;
    agd_pkg::t_out_item r_out;

    logic               w_advance;
    logic signed [31:0] w_x_ext;
    logic signed [31:0] w_y_ext;
    logic signed [31:0] w_sq_x_full;
    logic signed [31:0] w_sq_y_full;

    logic [31:0] w_mag2;
    logic        w_above;
    logic [31:0] w_shake_elapsed;
    logic [31:0] w_tap_elapsed;
    logic [31:0] w_face_elapsed;
    logic signed [16:0] w_z_dev;
    logic [16:0] w_z_abs;
    logic signed [16:0] w_x17;
    logic signed [16:0] w_y17;
    logic signed [16:0] w_z17;
    logic signed [16:0] w_th;
    logic signed [16:0] w_th_neg;
    agd_pkg::t_face w_cur_face;

    logic           n_shake_active;
    logic [31:0]    n_shake_begin;
    logic [31:0]    n_last_tap;
    agd_pkg::t_face n_reported_face;
    agd_pkg::t_face n_pending_face;
    logic [31:0]    n_pending_since;
    agd_pkg::t_out_item n_out;

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    // Squares are formed as the sample enters the input register.
    assign w_x_ext     = 32'(i_in_item.accel_x);
    assign w_y_ext     = 32'(i_in_item.accel_y);
    assign w_sq_x_full = w_x_ext * w_x_ext;
    assign w_sq_y_full = w_y_ext * w_y_ext;

    assign w_mag2  = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    assign w_above = w_mag2 > r_lim2;

    assign w_shake_elapsed = r_in.time_ms - r_shake_begin;
    assign w_tap_elapsed   = r_in.time_ms - r_last_tap;
    assign w_face_elapsed  = r_in.time_ms - r_pending_since;

    assign w_x17    = 17'(r_in.accel_x);
    assign w_y17    = 17'(r_in.accel_y);
    assign w_z17    = 17'(r_in.accel_z);
    assign w_th     = $signed({2'b00, r_face_thr});
    assign w_th_neg = -w_th;
    assign w_z_dev  = w_z17 - agd_pkg::ONE_G;
    assign w_z_abs  = w_z_dev[16] ? 17'(-w_z_dev) : w_z_dev;

    always_comb begin
        if (w_z17 > w_th) begin
            w_cur_face = agd_pkg::ORIENT_TOP;
        end else if (w_z17 < w_th_neg) begin
            w_cur_face = agd_pkg::ORIENT_BOTTOM;
        end else if (w_x17 > w_th) begin
            w_cur_face = agd_pkg::ORIENT_FRONT;
        end else if (w_x17 < w_th_neg) begin
            w_cur_face = agd_pkg::ORIENT_BACK;
        end else if (w_y17 > w_th) begin
            w_cur_face = agd_pkg::ORIENT_RIGHT;
        end else if (w_y17 < w_th_neg) begin
            w_cur_face = agd_pkg::ORIENT_LEFT;
        end else begin
            w_cur_face = agd_pkg::ORIENT_TOP;
        end
    end

    always_comb begin
        n_shake_active  = r_shake_active;
        n_shake_begin   = r_shake_begin;
        n_last_tap      = r_last_tap;
        n_reported_face = r_reported_face;
        n_pending_face  = r_pending_face;
        n_pending_since = r_pending_since;
        n_out.shake_seen = 1'b0;
        n_out.tap_seen   = 1'b0;
        n_out.new_face   = agd_pkg::ORIENT_NONE;

        if (!r_shake_active) begin
            if (w_above) begin
                n_shake_begin  = r_in.time_ms;
                n_shake_active = 1'b1;
            end
        end else if (w_above) begin
            if (w_shake_elapsed > {16'd0, r_shake_dur}) begin
                n_shake_active   = 1'b0;
                n_out.shake_seen = 1'b1;
            end
        end else begin
            n_shake_active = 1'b0;
        end

        if (w_z_abs > {2'b00, r_tap_thr} && w_tap_elapsed > {16'd0, r_tap_cool}) begin
            n_last_tap     = r_in.time_ms;
            n_out.tap_seen = 1'b1;
        end

        // A face different from the reported one must persist before it is reported.
        if (w_cur_face != r_reported_face) begin
            if (w_cur_face != r_pending_face) begin
                n_pending_face  = w_cur_face;
                n_pending_since = r_in.time_ms;
            end else if (w_face_elapsed >= {16'd0, r_face_stable}) begin
                n_reported_face = w_cur_face;
                n_out.new_face  = w_cur_face;
            end
        end else begin
            n_pending_face  = w_cur_face;
            n_pending_since = r_in.time_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim2        <= 32'(agd_pkg::RST_SHAKE_THRESHOLD)
                             * 32'(agd_pkg::RST_SHAKE_THRESHOLD);
            r_shake_dur   <= agd_pkg::RST_SHAKE_DURATION_MS;
            r_tap_thr     <= agd_pkg::RST_TAP_THRESHOLD;
            r_tap_cool    <= agd_pkg::RST_TAP_COOLDOWN_MS;
            r_face_thr    <= agd_pkg::RST_FACE_THRESHOLD;
            r_face_stable <= agd_pkg::RST_FACE_STABLE_MS;
        end else if (i_cfg_valid) begin
            case (agd_pkg::t_cfg_idx'(i_cfg_index))
                agd_pkg::CFG_SHAKE_THRESHOLD:
                    r_lim2 <= {16'd0, i_cfg_data} * {16'd0, i_cfg_data};
                agd_pkg::CFG_SHAKE_DURATION_MS: r_shake_dur   <= i_cfg_data;
                agd_pkg::CFG_TAP_THRESHOLD:     r_tap_thr     <= i_cfg_data[14:0];
                agd_pkg::CFG_TAP_COOLDOWN_MS:   r_tap_cool    <= i_cfg_data;
                agd_pkg::CFG_FACE_THRESHOLD:    r_face_thr    <= i_cfg_data[14:0];
                agd_pkg::CFG_FACE_STABLE_MS:    r_face_stable <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in   <= i_in_item;
            r_sq_x <= w_sq_x_full[30:0];
            r_sq_y <= w_sq_y_full[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shake_active  <= 1'b0;
            r_shake_begin   <= '0;
            r_last_tap      <= '0;
            r_reported_face <= agd_pkg::ORIENT_TOP;
            r_pending_face  <= agd_pkg::ORIENT_TOP;
            r_pending_since <= '0;
            r_out_valid     <= 1'b0;
        end else if (w_advance) begin
            r_shake_active  <= n_shake_active;
            r_shake_begin   <= n_shake_begin;
            r_last_tap      <= n_last_tap;
            r_reported_face <= n_reported_face;
            r_pending_face  <= n_pending_face;
            r_pending_since <= n_pending_since;
            r_out_valid     <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_out;
        end
    end

endmodule
